/* rtl/assert_macros.svh */
// Assertion helpers for the date offset block.
// Both expect clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DOD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dod assertion failed");

// next-cycle implication
`define DOD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dod assertion failed");

`endif

/* rtl/dod_pkg.sv */
`timescale 1ns / 1ps

package dod_pkg;

  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned MAX_YEAR        = 9999;
  localparam int unsigned YEAR_BIAS       = 400;
  localparam int unsigned DAYS_PER_ERA    = 146097;

  typedef struct packed {
    logic        func;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [19:0] day_count;
  } dod_in_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic        range_error;
  } dod_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_VALID,
    ST_DIV,
    ST_WAIT,
    ST_SERIAL,
    ST_OFFSET,
    ST_DOY,
    ST_FINAL
  } dod_state_t;

  // divisions run on the shared divider, in this order
  typedef enum logic [3:0] {
    OP_Y100,
    OP_Y400,
    OP_ERA,
    OP_D1460,
    OP_D36524,
    OP_D146096,
    OP_Y365,
    OP_YOE100,
    OP_MP153
  } dod_op_t;

  typedef struct packed {
    logic    load_in;
    logic    do_check;
    logic    do_valid;
    logic    do_serial;
    logic    do_offset;
    logic    do_doy;
    logic    load_out;
    logic    div_start;
    logic    div_store;
    dod_op_t div_op;
  } dod_cmd_t;

  typedef struct packed {
    logic bad;
    logic neg;
    logic div_done;
  } dod_sts_t;

  // month length, January is 1; codes outside 1..12 give 0
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of a month in a year that starts on March 1st
  function automatic logic [8:0] cum_days(input logic [3:0] mp);
    logic [8:0] c;
    case (mp)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd61;
      4'd3:    c = 9'd92;
      4'd4:    c = 9'd122;
      4'd5:    c = 9'd153;
      4'd6:    c = 9'd184;
      4'd7:    c = 9'd214;
      4'd8:    c = 9'd245;
      4'd9:    c = 9'd275;
      4'd10:   c = 9'd306;
      4'd11:   c = 9'd337;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/dod_div.sv */
`timescale 1ns / 1ps

// Constant divider by reciprocal multiplication, s = 23:
// q = (x * floor(2^23 / d)) >> 23 is low by at most one for any 23-bit x,
// so one compare and subtract finishes it. Three pipeline stages, and done rises together
// with the quotient and remainder registers. The caller guarantees the quotient fits in 9 bits.
module dod_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [22:0] dividend,
  input  logic [17:0] divisor,
  input  logic [16:0] recip,
  output logic        done,
  output logic [8:0]  quo,
  output logic [22:0] rem
);

  logic        s1_r, s2_r, s3_r, done_r;
  logic [22:0] x_r;
  logic [17:0] d_r;
  logic [16:0] m_r;
  logic [39:0] prod_r;
  logic [16:0] q_r;
  logic [22:0] qd_r;
  logic [22:0] rem_r, rem_nxt;
  logic [8:0]  quo_r, quo_nxt;
  logic [22:0] part;

  // estimate is never high, so the partial remainder stays below 2 * d
  always_comb begin
    part = x_r - qd_r;
    if (part >= 23'(d_r)) begin
      rem_nxt = part - 23'(d_r);
      quo_nxt = 9'(q_r + 17'd1);
    end else begin
      rem_nxt = part;
      quo_nxt = q_r[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
    if (start) begin
      x_r <= dividend;
      d_r <= divisor;
      m_r <= recip;
    end
    if (s1_r) begin
      prod_r <= 40'(x_r) * 40'(m_r);
    end
    if (s2_r) begin
      q_r  <= prod_r[39:23];
      qd_r <= 23'(35'(prod_r[39:23]) * 35'(d_r));
    end
    if (s3_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/dod_datapath.sv */
`timescale 1ns / 1ps

module dod_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  dod_pkg::dod_in_t  in_data,
  input  dod_pkg::dod_cmd_t cmd,
  output dod_pkg::dod_sts_t sts,
  output dod_pkg::dod_out_t out_data
);

  import dod_pkg::*;

  dod_in_t     in_r;
  dod_out_t    out_r;
  logic        err_r;
  logic [7:0]  q100y_r;
  logic [13:0] yy_r;
  logic [6:0]  q100_r;
  logic [4:0]  q400_r;
  logic [22:0] serial_r;
  logic [22:0] n_r;
  logic [5:0]  era_r;
  logic [17:0] doe_r;
  logic [6:0]  c1460_r;
  logic [2:0]  c36524_r;
  logic        c146096_r;
  logic [8:0]  yoe_r;
  logic [1:0]  yoe100_r;
  logic [8:0]  doy_r;
  logic [3:0]  mp_r;

  logic [26:0] mul_y;
  logic [13:0] hund;
  logic [13:0] r100;
  logic        leap;
  logic [4:0]  dim;
  logic        bad;
  logic [14:0] yy_sum;
  logic [3:0]  mp_in;
  logic [8:0]  doy_in;
  logic [22:0] serial_nxt;
  logic [23:0] nsum;
  logic [17:0] t365;
  logic [17:0] doy_full;
  logic [15:0] yr_sum;
  logic        year_ok;
  logic [3:0]  mm;
  logic [4:0]  dd;

  logic        div_done;
  logic [8:0]  div_quo;
  logic [22:0] div_rem;
  logic [22:0] div_dividend;
  logic [17:0] div_divisor;
  logic [16:0] div_recip;

  // y / 100 by reciprocal, exact for 14-bit years
  assign mul_y = 27'(in_r.start_year) * 27'd5243;

  always_comb begin
    hund = 14'(q100y_r * 14'd100);
    r100 = in_r.start_year - hund;
    leap = ((in_r.start_year[1:0] == 2'd0) && (r100 != 14'd0)) ||
           ((r100 == 14'd0) && (q100y_r[1:0] == 2'd0));
    dim  = days_in_month(in_r.start_month, leap);
    bad  = (in_r.start_year > 14'(MAX_YEAR)) || (in_r.start_month == 4'd0) ||
           (in_r.start_month > 4'(MONTHS_PER_YEAR)) || (in_r.start_day == 5'd0) ||
           (in_r.start_day > dim);
    yy_sum = 15'(in_r.start_year) + 15'(YEAR_BIAS) - 15'(in_r.start_month <= 4'd2);
  end

  always_comb begin
    mp_in      = (in_r.start_month >= 4'd3) ? in_r.start_month - 4'd3
                                            : in_r.start_month + 4'd9;
    doy_in     = cum_days(mp_in) + 9'(in_r.start_day) - 9'd1;
    serial_nxt = 23'(yy_r * 23'd365) + 23'(yy_r >> 2) - 23'(q100_r) + 23'(q400_r)
               + 23'(doy_in);
    nsum       = in_r.func ? 24'(serial_r) - 24'(in_r.day_count)
                           : 24'(serial_r) + 24'(in_r.day_count);
    t365       = doe_r - 18'(c1460_r) + 18'(c36524_r) - 18'(c146096_r);
    doy_full   = doe_r - (18'(yoe_r * 18'd365) + 18'(yoe_r >> 2) - 18'(yoe100_r));
  end

  // March-based year: January and February belong to the next calendar year
  always_comb begin
    yr_sum  = 16'(yoe_r) + 16'(era_r * 16'd400) + 16'(mp_r >= 4'd10);
    year_ok = (yr_sum >= 16'(YEAR_BIAS)) && (yr_sum <= 16'(YEAR_BIAS + MAX_YEAR));
    mm      = (mp_r < 4'd10) ? mp_r + 4'd3 : mp_r - 4'd9;
    dd      = 5'(doy_r - cum_days(mp_r) + 9'd1);
  end

  // recip is floor(2^23 / divisor)
  always_comb begin
    unique case (cmd.div_op)
      OP_Y100: begin
        div_dividend = 23'(yy_r);
        div_divisor  = 18'd100;
        div_recip    = 17'd83886;
      end
      OP_Y400: begin
        div_dividend = 23'(yy_r);
        div_divisor  = 18'd400;
        div_recip    = 17'd20971;
      end
      OP_ERA: begin
        div_dividend = n_r;
        div_divisor  = 18'(DAYS_PER_ERA);
        div_recip    = 17'd57;
      end
      OP_D1460: begin
        div_dividend = 23'(doe_r);
        div_divisor  = 18'd1460;
        div_recip    = 17'd5745;
      end
      OP_D36524: begin
        div_dividend = 23'(doe_r);
        div_divisor  = 18'd36524;
        div_recip    = 17'd229;
      end
      OP_D146096: begin
        div_dividend = 23'(doe_r);
        div_divisor  = 18'd146096;
        div_recip    = 17'd57;
      end
      OP_Y365: begin
        div_dividend = 23'(t365);
        div_divisor  = 18'd365;
        div_recip    = 17'd22982;
      end
      OP_YOE100: begin
        div_dividend = 23'(yoe_r);
        div_divisor  = 18'd100;
        div_recip    = 17'd83886;
      end
      OP_MP153: begin
        div_dividend = 23'(doy_r) * 23'd5 + 23'd2;
        div_divisor  = 18'd153;
        div_recip    = 17'd54827;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = 18'd1;
        div_recip    = 17'd0;
      end
    endcase
  end

  dod_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .recip    (div_recip),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r  <= in_data;
      err_r <= 1'b0;
    end
    if (cmd.do_check) begin
      q100y_r <= mul_y[26:19];
    end
    if (cmd.do_valid) begin
      yy_r <= yy_sum[13:0];
      if (bad) begin
        err_r <= 1'b1;
      end
    end
    if (cmd.do_serial) begin
      serial_r <= serial_nxt;
    end
    if (cmd.do_offset) begin
      n_r <= nsum[22:0];
      if (nsum[23]) begin
        err_r <= 1'b1;
      end
    end
    if (cmd.do_doy) begin
      doy_r <= doy_full[8:0];
    end
    if (cmd.div_store) begin
      case (cmd.div_op)
        OP_Y100:    q100_r    <= div_quo[6:0];
        OP_Y400:    q400_r    <= div_quo[4:0];
        OP_ERA: begin
          era_r <= div_quo[5:0];
          doe_r <= div_rem[17:0];
        end
        OP_D1460:   c1460_r   <= div_quo[6:0];
        OP_D36524:  c36524_r  <= div_quo[2:0];
        OP_D146096: c146096_r <= div_quo[0];
        OP_Y365:    yoe_r     <= div_quo[8:0];
        OP_YOE100:  yoe100_r  <= div_quo[1:0];
        OP_MP153:   mp_r      <= div_quo[3:0];
        default:    ;
      endcase
    end
    if (cmd.load_out) begin
      if (err_r || !year_ok) begin
        out_r <= '{result_year: '0, result_month: '0, result_day: '0, range_error: 1'b1};
      end else begin
        out_r <= '{result_year: yr_sum[13:0] - 14'(YEAR_BIAS), result_month: mm,
                   result_day: dd, range_error: 1'b0};
      end
    end
  end

  assign sts.bad      = bad;
  assign sts.neg      = nsum[23];
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule

/* rtl/dod_ctrl.sv */
`timescale 1ns / 1ps

module dod_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dod_pkg::dod_sts_t sts,
  output dod_pkg::dod_cmd_t cmd
);

  import dod_pkg::*;

  dod_state_t state_r, state_nxt;
  dod_op_t    op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_Y100;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = op_r;
    state_nxt  = state_r;
    op_nxt     = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.do_check = 1'b1;
        state_nxt    = ST_VALID;
      end
      ST_VALID: begin
        cmd.do_valid = 1'b1;
        if (sts.bad) begin
          state_nxt = ST_FINAL;
        end else begin
          op_nxt    = OP_Y100;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_DIV;
          unique case (op_r)
            OP_Y100:    op_nxt    = OP_Y400;
            OP_Y400:    state_nxt = ST_SERIAL;
            OP_ERA:     op_nxt    = OP_D1460;
            OP_D1460:   op_nxt    = OP_D36524;
            OP_D36524:  op_nxt    = OP_D146096;
            OP_D146096: op_nxt    = OP_Y365;
            OP_Y365:    op_nxt    = OP_YOE100;
            OP_YOE100:  state_nxt = ST_DOY;
            OP_MP153:   state_nxt = ST_FINAL;
            default:    state_nxt = ST_FINAL;
          endcase
        end
      end
      ST_SERIAL: begin
        cmd.do_serial = 1'b1;
        state_nxt     = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd.do_offset = 1'b1;
        if (sts.neg) begin
          state_nxt = ST_FINAL;
        end else begin
          op_nxt    = OP_ERA;
          state_nxt = ST_DIV;
        end
      end
      ST_DOY: begin
        cmd.do_doy = 1'b1;
        op_nxt     = OP_MP153;
        state_nxt  = ST_DIV;
      end
      ST_FINAL: begin
        // wait for room in the output register
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/date_offset_by_days.sv */
`timescale 1ns / 1ps
// Sequencing: after an input transfer out_valid rises once the last division is stored;
// an invalid start date skips all divisions and a day number before the epoch skips seven.
// A new item is taken only once the previous one has left the sequencer; a valid date
// runs nine constant divisions one after another on a shared reciprocal divider, and a
// result still held in the output register delays the next one.
// Reset: synchronous active-low rst_n returns the sequencer to idle and empties
// the output register.
module date_offset_by_days (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dod_pkg::dod_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dod_pkg::dod_out_t out_data
);

  import dod_pkg::*;

  dod_cmd_t cmd;
  dod_sts_t sts;

  dod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dod_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* rtl/dod_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dod_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dod_pkg::dod_out_t out_data
);

  import dod_pkg::*;

  logic err_zero;
  logic date_sane;

  assign err_zero  = (out_data.result_year == 14'd0) && (out_data.result_month == 4'd0) &&
                     (out_data.result_day == 5'd0);
  assign date_sane = (out_data.result_month >= 4'd1) && (out_data.result_month <= 4'd12) &&
                     (out_data.result_day >= 5'd1) && (out_data.result_day <= 5'd31) &&
                     (out_data.result_year <= 14'(MAX_YEAR));

  `DOD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `DOD_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `DOD_ASSERT_IMP(a_error_zeroes, out_valid && out_data.range_error, err_zero)
  `DOD_ASSERT_IMP(a_result_in_range, out_valid && !out_data.range_error, date_sane)

endmodule

bind date_offset_by_days dod_checker u_dod_checker (.*);
